[hdl/assert_macros.svh]
// Assertion macros shared by the RTL of the drop-oldest FIFO.
// No dependencies; each macro expects i_clk and i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Check that a condition implies another one in the next cycle.
`define ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |=> (prop)) else $error(msg);

`endif

[hdl/dofifo_pkg.sv]
// Package for the drop-oldest FIFO: opcodes, field widths and reset values.
// No dependencies.
package dofifo_pkg;

    // Fixed field widths.
    localparam int HANDLE_W  = 32;
    localparam int OP_W      = 2;
    localparam int CNT_W     = 4;
    localparam int TOTAL_W   = 32;
    localparam int LIMIT_W   = 4;
    // Width for comparing the count against the limit, for depths up to 510.
    localparam int CALC_W    = 9;
    localparam int M_TDATA_W = 104;
    localparam int M_TUSER_W = 2;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd6;

    typedef enum logic [OP_W-1:0] {
        OP_ENQUEUE = 2'd0,
        OP_DEQUEUE = 2'd1,
        OP_PEEK    = 2'd2,
        OP_FLUSH   = 2'd3
    } t_opcode;

endpackage

[hdl/drop_oldest_fifo_with_stats.sv]
// Top level of the drop-oldest FIFO of frame handles with statistics.
// Depends on dofifo_pkg and assert_macros.svh.
//
// Channel  | Direction | Contents (lowest bits first)
// ---------+-----------+-------------------------------------------------------
// s        | in        | tuser: opcode; tdata: handle_in
// m        | out       | tuser: handle_valid, dropped_now;
//          |           | tdata: handle_out, occupancy, enqueue_total, drop_total
// cfg      | in        | wdata: depth_limit, taken when i_cfg_we is high
//
// One item per cycle while the m side takes results: an item is held in the
// input register, is processed in one pass, and its result appears in the
// output register. The oldest handle is prefetched from the slot memory into
// a register, so an item never waits for a memory read. Reset is synchronous;
// the slot memory is not cleared. A stall on the m side holds the result and,
// once the input register is full, deasserts o_s_tready.
`include "assert_macros.svh"

module drop_oldest_fifo_with_stats #(
    parameter int DEPTH = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration write.
    input  logic                                i_cfg_we,
    input  logic [dofifo_pkg::LIMIT_W-1:0]      i_cfg_wdata,   // depth_limit
    // Input stream.
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [dofifo_pkg::HANDLE_W-1:0]     i_s_tdata,     // handle_in
    input  logic [dofifo_pkg::OP_W-1:0]         i_s_tuser,     // opcode
    // Result stream.
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // handle_out[31:0], occupancy[35:32], enqueue_total[67:36],
    // drop_total[99:68], zero[103:100]
    output logic [dofifo_pkg::M_TDATA_W-1:0]    o_m_tdata,
    // handle_valid[0], dropped_now[1]
    output logic [dofifo_pkg::M_TUSER_W-1:0]    o_m_tuser
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    // Occupancy can reach DEPTH, so its register is sized from the depth.
    localparam int CNT_IW = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [dofifo_pkg::CALC_W-1:0] DEPTH_C = dofifo_pkg::CALC_W'(DEPTH);
    localparam logic [dofifo_pkg::TOTAL_W-1:0] TOTAL_MAX = '1;

    // Configuration register.
    logic [dofifo_pkg::LIMIT_W-1:0]  r_limit;

    // Input register.
    logic                            r_in_vld;
    dofifo_pkg::t_opcode             r_in_op;
    logic [dofifo_pkg::HANDLE_W-1:0] r_in_handle;

    // Queue state.
    logic [dofifo_pkg::HANDLE_W-1:0] r_mem [DEPTH];
    logic [dofifo_pkg::HANDLE_W-1:0] r_head_data;
    logic [PTR_W-1:0]                r_head;
    logic [PTR_W-1:0]                r_tail;
    logic [CNT_IW-1:0]               r_cnt;
    logic [dofifo_pkg::TOTAL_W-1:0]  r_enq_tot;
    logic [dofifo_pkg::TOTAL_W-1:0]  r_drop_tot;

    // Result register.
    logic                            r_out_vld;
    logic [dofifo_pkg::M_TDATA_W-1:0] r_out_data;
    logic [dofifo_pkg::M_TUSER_W-1:0] r_out_user;

    // Next values.
    logic [PTR_W-1:0]                n_head;
    logic [PTR_W-1:0]                n_tail;
    logic [CNT_IW-1:0]               n_cnt;
    logic [dofifo_pkg::TOTAL_W-1:0]  n_enq_tot;
    logic [dofifo_pkg::TOTAL_W-1:0]  n_drop_tot;
    logic [dofifo_pkg::HANDLE_W-1:0] n_handle_out;
    logic                            n_handle_vld;
    logic                            n_dropped;

    logic                            w_go;
    logic                            w_wr;
    logic [dofifo_pkg::CALC_W-1:0]   w_limit;
    logic                            w_over;

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        next_ptr = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
    endfunction

    // Handshake: the held item moves on when the result register frees up.
    assign w_go       = r_in_vld && (!r_out_vld || i_m_tready);
    assign o_s_tready = !r_in_vld || w_go;
    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

    assign w_wr = w_go && (r_in_op == dofifo_pkg::OP_ENQUEUE);

    // A limit above the storage acts as the storage size.
    assign w_limit = (dofifo_pkg::CALC_W'(r_limit) > DEPTH_C) ? DEPTH_C
                                                              : dofifo_pkg::CALC_W'(r_limit);
    assign w_over  = (dofifo_pkg::CALC_W'(r_cnt) + dofifo_pkg::CALC_W'(1)) > w_limit;

    // Single pass over one operation.
    always_comb begin
        n_head       = r_head;
        n_tail       = r_tail;
        n_cnt        = r_cnt;
        n_enq_tot    = r_enq_tot;
        n_drop_tot   = r_drop_tot;
        n_handle_out = '0;
        n_handle_vld = 1'b0;
        n_dropped    = 1'b0;
        if (w_go) begin
            case (r_in_op)
                dofifo_pkg::OP_ENQUEUE: begin
                    n_tail    = next_ptr(r_tail);
                    n_enq_tot = (r_enq_tot == TOTAL_MAX) ? r_enq_tot
                                                         : r_enq_tot + 1'b1;
                    if (w_over) begin
                        n_head     = next_ptr(r_head);
                        n_drop_tot = (r_drop_tot == TOTAL_MAX) ? r_drop_tot
                                                               : r_drop_tot + 1'b1;
                        n_dropped  = 1'b1;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
                dofifo_pkg::OP_DEQUEUE,
                dofifo_pkg::OP_PEEK: begin
                    if (r_cnt != '0) begin
                        n_handle_out = r_head_data;
                        n_handle_vld = 1'b1;
                        if (r_in_op == dofifo_pkg::OP_DEQUEUE) begin
                            n_head = next_ptr(r_head);
                            n_cnt  = r_cnt - 1'b1;
                        end
                    end
                end
                dofifo_pkg::OP_FLUSH: begin
                    n_head = r_tail;
                    n_cnt  = '0;
                end
                default: begin
                    n_cnt = r_cnt;
                end
            endcase
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit    <= dofifo_pkg::LIMIT_RESET;
            r_in_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
            r_head     <= '0;
            r_tail     <= '0;
            r_cnt      <= '0;
            r_enq_tot  <= '0;
            r_drop_tot <= '0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            if (o_s_tready) begin
                r_in_vld <= i_s_tvalid;
            end
            if (w_go) begin
                r_out_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
            r_head     <= n_head;
            r_tail     <= n_tail;
            r_cnt      <= n_cnt;
            r_enq_tot  <= n_enq_tot;
            r_drop_tot <= n_drop_tot;
        end
    end

    // Input and result payload.
    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_op     <= dofifo_pkg::t_opcode'(i_s_tuser);
            r_in_handle <= i_s_tdata;
        end
        if (w_go) begin
            r_out_data <= {4'd0, n_drop_tot, n_enq_tot, dofifo_pkg::CNT_W'(n_cnt),
                           n_handle_out};
            r_out_user <= {n_dropped, n_handle_vld};
        end
    end

    // Slot memory with the oldest entry prefetched for the next item.
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_tail] <= r_in_handle;
        end
        if (w_wr && (r_tail == n_head)) begin
            r_head_data <= r_in_handle;
        end else begin
            r_head_data <= r_mem[n_head];
        end
    end

    // Checks on the queue state.
    `ASSERT_CLK(a_cnt_bound, (dofifo_pkg::CALC_W'(r_cnt) <= DEPTH_C),
        "occupancy exceeds storage")
    `ASSERT_CLK(a_drop_le_enq, (r_drop_tot <= r_enq_tot),
        "drop total exceeds enqueue total")
    `ASSERT_CLK(a_valid_or_drop, (!(o_m_tvalid && o_m_tuser[0] && o_m_tuser[1])),
        "result both returns a handle and reports a drop")
    `ASSERT_NEXT(a_flush_empty, (w_go && (r_in_op == dofifo_pkg::OP_FLUSH)),
        ((r_cnt == '0) && (r_head == r_tail)), "flush left entries behind")

endmodule
